// File: rtl/cpq_pkg.sv
// ----------------------------------------------------------------------------
// cpq_pkg - shared constants and types
// Widths, command and result codes, and the control and status words that
// join the convex polygon controller to its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cpq_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 2);
   localparam int LOOP_DEPTH   = MAX_VERTICES + 1;
   localparam int LIDX_W       = $clog2(LOOP_DEPTH);

   localparam int CMD_W   = 3;
   localparam int KIND_W  = 2;
   localparam int VIDX_W  = 4;
   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int MID_W   = DIFF_W + 2;
   localparam int MUL_W   = MID_W;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int MAG_W   = 2 * DIFF_W;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int WIDE_W  = SQ_W + MAG_W;
   localparam int STEP_W  = $clog2(MAG_W);

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAG_W - 1);

   localparam logic [CMD_W-1:0] CMD_CLEAR    = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_LOAD     = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_BUILD    = CMD_W'(2);
   localparam logic [CMD_W-1:0] CMD_SUPPORT  = CMD_W'(3);
   localparam logic [CMD_W-1:0] CMD_CONTAINS = CMD_W'(4);

   localparam logic [KIND_W-1:0] KIND_ORDER    = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_SUPPORT  = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_CONTAINS = KIND_W'(2);
   localparam logic [KIND_W-1:0] KIND_ERROR    = KIND_W'(3);

   typedef struct packed {
      logic              latch;
      logic              clear;
      logic              load;
      logic              pt_from_loop;
      logic [IDX_W-1:0]  pt_addr;
      logic [LIDX_W-1:0] lp_addr;
      logic              first;
      logic              min_step;
      logic              build_init;
      logic              step_init;
      logic              cand_diff;
      logic              mul;
      logic              sum;
      logic              take;
      logic              wide_start;
      logic              wide_phase2;
      logic              advance;
      logic              sup_step;
      logic              con_a;
      logic              con_diff;
      logic              con_mid;
      logic              con_check;
      logic              emit;
      logic [KIND_W-1:0] kind;
      logic              emit_last;
   } ctl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] loop_len;
      logic             full;
      logic             skip;
      logic             dec_take;
      logic             dec_wide;
      logic             wide_busy;
      logic             wide_take;
      logic             cross_neg;
      logic             out_free;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/cpq_serial_mul.sv
// ----------------------------------------------------------------------------
// cpq_serial_mul - shift-add multiplier
// Unsigned product of a wide operand and a MAG_W-bit operand, one bit of the
// short operand per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpq_serial_mul (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [cpq_pkg::SQ_W-1:0]   a,
   input  wire logic [cpq_pkg::MAG_W-1:0]  b,
   output logic                            busy,
   output logic [cpq_pkg::WIDE_W-1:0]      product
);

   logic                          busy_ff, busy_in;
   logic [cpq_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic [cpq_pkg::WIDE_W-1:0]    acc_ff, acc_in;
   logic [cpq_pkg::WIDE_W-1:0]    ash_ff, ash_in;
   logic [cpq_pkg::MAG_W-1:0]     bsh_ff, bsh_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      ash_in  = ash_ff;
      bsh_in  = bsh_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         ash_in  = cpq_pkg::WIDE_W'(a);
         bsh_in  = b;
      end else if (busy_ff) begin
         if (bsh_ff[0]) begin
            acc_in = acc_ff + ash_ff;
         end
         ash_in = ash_ff << 1;
         bsh_in = bsh_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == cpq_pkg::STEP_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      ash_ff <= ash_in;
      bsh_ff <= bsh_in;
   end

   assign busy    = busy_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// File: rtl/cpq_datapath.sv
// ----------------------------------------------------------------------------
// cpq_datapath - vertex store, loop store and arithmetic
// Holds the points and the built loop, computes edge vectors, products,
// cosine ranking, dot products and edge tests, and owns the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module cpq_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [cpq_pkg::CMD_W-1:0]            req_command,
   input  wire logic signed [cpq_pkg::COORD_W-1:0]   req_coord_x,
   input  wire logic signed [cpq_pkg::COORD_W-1:0]   req_coord_y,
   input  wire cpq_pkg::ctl_type                     ctl,
   output cpq_pkg::status_type                       sts,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_valid,
   output logic [cpq_pkg::KIND_W-1:0]                rsp_result_kind,
   output logic [cpq_pkg::VIDX_W-1:0]                rsp_vertex_index,
   output logic signed [cpq_pkg::COORD_W-1:0]        rsp_vertex_x,
   output logic signed [cpq_pkg::COORD_W-1:0]        rsp_vertex_y,
   output logic                                      rsp_inside_res,
   output logic                                      rsp_last
);

   localparam int IDX_W   = cpq_pkg::IDX_W;
   localparam int CNT_W   = cpq_pkg::CNT_W;
   localparam int LIDX_W  = cpq_pkg::LIDX_W;
   localparam int COORD_W = cpq_pkg::COORD_W;
   localparam int DIFF_W  = cpq_pkg::DIFF_W;
   localparam int MID_W   = cpq_pkg::MID_W;
   localparam int MUL_W   = cpq_pkg::MUL_W;
   localparam int PROD_W  = cpq_pkg::PROD_W;
   localparam int MAG_W   = cpq_pkg::MAG_W;
   localparam int SQ_W    = cpq_pkg::SQ_W;
   localparam int WIDE_W  = cpq_pkg::WIDE_W;

   logic signed [COORD_W-1:0] pt_x_mem [cpq_pkg::MAX_VERTICES];
   logic signed [COORD_W-1:0] pt_y_mem [cpq_pkg::MAX_VERTICES];
   logic [IDX_W-1:0]          loop_mem [cpq_pkg::LOOP_DEPTH];

   logic signed [COORD_W-1:0] rd_x_ff, rd_y_ff;
   logic [IDX_W-1:0]          lp_rd_ff;
   logic [IDX_W-1:0]          pt_rd_addr;
   logic                      lp_wr_en;
   logic [LIDX_W-1:0]         lp_wr_addr;
   logic [IDX_W-1:0]          lp_wr_data;

   logic [cpq_pkg::CMD_W-1:0]         cmd_ff, cmd_in;
   logic signed [COORD_W-1:0]         qx_ff, qx_in, qy_ff, qy_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CNT_W-1:0]                  loop_len_ff, loop_len_in;
   logic [cpq_pkg::MAX_VERTICES-1:0]  visited_ff, visited_in;
   logic [IDX_W-1:0]                  cur_ff, cur_in, best_ff, best_in;
   logic signed [COORD_W-1:0]         cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_W-1:0]         best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic signed [DIFF_W-1:0]          rx_ff, rx_in, ry_ff, ry_in;
   logic signed [DIFF_W-1:0]          ex_ff, ex_in, ey_ff, ey_in;
   logic signed [DIFF_W-1:0]          pdx_ff, pdx_in, pdy_ff, pdy_in;
   logic signed [MID_W-1:0]           mx_ff, mx_in, my_ff, my_in;
   logic signed [PROD_W-1:0]          m0_ff, m1_ff, m2_ff, m3_ff;
   logic signed [PROD_W-1:0]          m0_in, m1_in, m2_in, m3_in;
   logic signed [PROD_W-1:0]          s0_ff, s0_in, s1_ff, s1_in;
   logic signed [PROD_W-1:0]          bd_ff, bd_in, be_ff, be_in;
   logic                              have_ff, have_in, bzero_ff, bzero_in;
   logic                              inside_ff, inside_in;

   logic signed [MUL_W-1:0] a0, b0, a1, b1, a2, b2, a3, b3;

   logic              e_zero, r_zero, d_neg, bd_neg;
   logic [PROD_W-1:0] d_abs, bd_abs;
   logic [MAG_W-1:0]  d_mag, bd_mag;
   logic [SQ_W-1:0]   l_a, r_a;
   logic [MAG_W-1:0]  l_b, r_b;
   logic              l_busy, r_busy;
   logic [WIDE_W-1:0] l_prod, r_prod;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [cpq_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [cpq_pkg::VIDX_W-1:0] vidx_ff, vidx_in;
   logic signed [COORD_W-1:0]  ox_ff, ox_in, oy_ff, oy_in;
   logic                       oin_ff, oin_in, olast_ff, olast_in;

   // memories
   assign pt_rd_addr = ctl.pt_from_loop ? lp_rd_ff : ctl.pt_addr;
   assign lp_wr_en   = ctl.build_init | ctl.advance;
   assign lp_wr_addr = ctl.build_init ? '0 : LIDX_W'(loop_len_ff);
   assign lp_wr_data = ctl.build_init ? cur_ff : best_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         pt_x_mem[IDX_W'(count_ff)] <= qx_ff;
         pt_y_mem[IDX_W'(count_ff)] <= qy_ff;
      end
      if (lp_wr_en) begin
         loop_mem[lp_wr_addr] <= lp_wr_data;
      end
      rd_x_ff  <= pt_x_mem[pt_rd_addr];
      rd_y_ff  <= pt_y_mem[pt_rd_addr];
      lp_rd_ff <= loop_mem[ctl.lp_addr];
   end

   // ranking of the current candidate
   assign e_zero = (s0_ff == '0);
   assign r_zero = (rx_ff == '0) && (ry_ff == '0);
   assign d_neg  = s1_ff[PROD_W-1];
   assign bd_neg = bd_ff[PROD_W-1];
   assign d_abs  = d_neg ? -s1_ff : s1_ff;
   assign bd_abs = bd_neg ? -bd_ff : bd_ff;
   assign d_mag  = d_abs[MAG_W-1:0];
   assign bd_mag = bd_abs[MAG_W-1:0];

   assign l_a = ctl.wide_phase2 ? l_prod[SQ_W-1:0] : SQ_W'(d_mag);
   assign l_b = ctl.wide_phase2 ? be_ff[MAG_W-1:0] : d_mag;
   assign r_a = ctl.wide_phase2 ? r_prod[SQ_W-1:0] : SQ_W'(bd_mag);
   assign r_b = ctl.wide_phase2 ? s0_ff[MAG_W-1:0] : bd_mag;

   cpq_serial_mul u_mul_l (
      .clock   (clock),
      .reset   (reset),
      .start   (ctl.wide_start),
      .a       (l_a),
      .b       (l_b),
      .busy    (l_busy),
      .product (l_prod)
   );

   cpq_serial_mul u_mul_r (
      .clock   (clock),
      .reset   (reset),
      .start   (ctl.wide_start),
      .a       (r_a),
      .b       (r_b),
      .busy    (r_busy),
      .product (r_prod)
   );

   // multiplier operands
   always_comb begin
      a0 = MUL_W'(ex_ff);
      b0 = MUL_W'(ex_ff);
      a1 = MUL_W'(ey_ff);
      b1 = MUL_W'(ey_ff);
      a2 = MUL_W'(rx_ff);
      b2 = MUL_W'(ex_ff);
      a3 = MUL_W'(ry_ff);
      b3 = MUL_W'(ey_ff);
      if (cmd_ff == cpq_pkg::CMD_SUPPORT) begin
         a0 = MUL_W'(qx_ff);
         b0 = MUL_W'(rd_x_ff);
         a1 = MUL_W'(qy_ff);
         b1 = MUL_W'(rd_y_ff);
      end else if (cmd_ff == cpq_pkg::CMD_CONTAINS) begin
         a0 = MUL_W'(ey_ff);
         b0 = mx_ff;
         a1 = MUL_W'(ex_ff);
         b1 = my_ff;
      end
   end

   always_comb begin
      cmd_in      = cmd_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      count_in    = count_ff;
      loop_len_in = loop_len_ff;
      visited_in  = visited_ff;
      cur_in      = cur_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      best_in     = best_ff;
      best_x_in   = best_x_ff;
      best_y_in   = best_y_ff;
      rx_in       = rx_ff;
      ry_in       = ry_ff;
      ex_in       = ex_ff;
      ey_in       = ey_ff;
      pdx_in      = pdx_ff;
      pdy_in      = pdy_ff;
      mx_in       = mx_ff;
      my_in       = my_ff;
      m0_in       = m0_ff;
      m1_in       = m1_ff;
      m2_in       = m2_ff;
      m3_in       = m3_ff;
      s0_in       = s0_ff;
      s1_in       = s1_ff;
      bd_in       = bd_ff;
      be_in       = be_ff;
      have_in     = have_ff;
      bzero_in    = bzero_ff;
      inside_in   = inside_ff;

      if (ctl.latch) begin
         cmd_in    = req_command;
         qx_in     = req_coord_x;
         qy_in     = req_coord_y;
         inside_in = 1'b1;
      end
      if (ctl.clear) begin
         count_in    = '0;
         loop_len_in = '0;
         visited_in  = '0;
      end
      if (ctl.load) begin
         count_in    = count_ff + 1'b1;
         loop_len_in = '0;
         visited_in  = '0;
      end
      if (ctl.min_step && (ctl.first || (rd_x_ff < cur_x_ff))) begin
         cur_in   = ctl.pt_addr;
         cur_x_in = rd_x_ff;
         cur_y_in = rd_y_ff;
      end
      if (ctl.build_init) begin
         loop_len_in = CNT_W'(1);
         visited_in  = '0;
         rx_in       = '0;
         ry_in       = DIFF_W'(1);
      end
      if (ctl.step_init) begin
         have_in   = 1'b0;
         bzero_in  = 1'b1;
         best_in   = cur_ff;
         best_x_in = cur_x_ff;
         best_y_in = cur_y_ff;
         bd_in     = '0;
         be_in     = '0;
      end
      if (ctl.cand_diff) begin
         ex_in = DIFF_W'(rd_x_ff) - DIFF_W'(cur_x_ff);
         ey_in = DIFF_W'(rd_y_ff) - DIFF_W'(cur_y_ff);
      end
      if (ctl.mul) begin
         m0_in = a0 * b0;
         m1_in = a1 * b1;
         m2_in = a2 * b2;
         m3_in = a3 * b3;
      end
      if (ctl.sum) begin
         s0_in = (cmd_ff == cpq_pkg::CMD_CONTAINS) ? (m0_ff - m1_ff) : (m0_ff + m1_ff);
         s1_in = m2_ff + m3_ff;
      end
      if (ctl.take) begin
         have_in   = 1'b1;
         bzero_in  = e_zero;
         best_in   = ctl.pt_addr;
         best_x_in = rd_x_ff;
         best_y_in = rd_y_ff;
         bd_in     = s1_ff;
         be_in     = s0_ff;
      end
      if (ctl.advance) begin
         visited_in[best_ff] = 1'b1;
         loop_len_in = loop_len_ff + 1'b1;
         rx_in       = DIFF_W'(best_x_ff) - DIFF_W'(cur_x_ff);
         ry_in       = DIFF_W'(best_y_ff) - DIFF_W'(cur_y_ff);
         cur_in      = best_ff;
         cur_x_in    = best_x_ff;
         cur_y_in    = best_y_ff;
      end
      if (ctl.sup_step && (ctl.first || (s0_ff > bd_ff))) begin
         bd_in     = s0_ff;
         best_in   = ctl.pt_addr;
         best_x_in = rd_x_ff;
         best_y_in = rd_y_ff;
      end
      if (ctl.con_a) begin
         cur_x_in = rd_x_ff;
         cur_y_in = rd_y_ff;
      end
      if (ctl.con_diff) begin
         ex_in  = DIFF_W'(rd_x_ff) - DIFF_W'(cur_x_ff);
         ey_in  = DIFF_W'(rd_y_ff) - DIFF_W'(cur_y_ff);
         pdx_in = DIFF_W'(qx_ff) - DIFF_W'(cur_x_ff);
         pdy_in = DIFF_W'(qy_ff) - DIFF_W'(cur_y_ff);
      end
      if (ctl.con_mid) begin
         mx_in = (MID_W'(pdx_ff) <<< 1) - MID_W'(ex_ff);
         my_in = (MID_W'(pdy_ff) <<< 1) - MID_W'(ey_ff);
      end
      if (ctl.con_check && s0_ff[PROD_W-1]) begin
         inside_in = 1'b0;
      end
   end

   // result word
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      kind_in      = kind_ff;
      vidx_in      = vidx_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      oin_in       = oin_ff;
      olast_in     = olast_ff;
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = ctl.kind;
         vidx_in      = '0;
         ox_in        = '0;
         oy_in        = '0;
         oin_in       = 1'b0;
         olast_in     = ctl.emit_last;
         unique case (ctl.kind)
            cpq_pkg::KIND_ORDER: begin
               vidx_in = cpq_pkg::VIDX_W'(lp_rd_ff);
            end
            cpq_pkg::KIND_SUPPORT: begin
               vidx_in = cpq_pkg::VIDX_W'(best_ff);
               ox_in   = best_x_ff;
               oy_in   = best_y_ff;
            end
            cpq_pkg::KIND_CONTAINS: begin
               oin_in = inside_ff;
            end
            default: begin
               vidx_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         loop_len_ff  <= '0;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         loop_len_ff  <= loop_len_in;
         visited_ff   <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      cur_ff    <= cur_in;
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      best_ff   <= best_in;
      best_x_ff <= best_x_in;
      best_y_ff <= best_y_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      ex_ff     <= ex_in;
      ey_ff     <= ey_in;
      pdx_ff    <= pdx_in;
      pdy_ff    <= pdy_in;
      mx_ff     <= mx_in;
      my_ff     <= my_in;
      m0_ff     <= m0_in;
      m1_ff     <= m1_in;
      m2_ff     <= m2_in;
      m3_ff     <= m3_in;
      s0_ff     <= s0_in;
      s1_ff     <= s1_in;
      bd_ff     <= bd_in;
      be_ff     <= be_in;
      have_ff   <= have_in;
      bzero_ff  <= bzero_in;
      inside_ff <= inside_in;
      kind_ff   <= kind_in;
      vidx_ff   <= vidx_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      oin_ff    <= oin_in;
      olast_ff  <= olast_in;
   end

   // status
   always_comb begin
      sts           = '0;
      sts.cmd       = cmd_ff;
      sts.count     = count_ff;
      sts.loop_len  = loop_len_ff;
      sts.full      = (count_ff == CNT_W'(cpq_pkg::MAX_VERTICES));
      sts.skip      = (ctl.pt_addr == cur_ff) || visited_ff[ctl.pt_addr];
      sts.dec_take  = !have_ff || (!e_zero && (bzero_ff || (!r_zero && !d_neg && bd_neg)));
      sts.dec_wide  = have_ff && !e_zero && !bzero_ff && !r_zero && (d_neg == bd_neg);
      sts.wide_busy = l_busy | r_busy;
      sts.wide_take = d_neg ? (l_prod < r_prod) : (l_prod > r_prod);
      sts.cross_neg = s0_ff[PROD_W-1];
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_vertex_index = vidx_ff;
   assign rsp_vertex_x     = ox_ff;
   assign rsp_vertex_y     = oy_ff;
   assign rsp_inside_res   = oin_ff;
   assign rsp_last         = olast_ff;

endmodule

`default_nettype wire

// File: rtl/cpq_controller.sv
// ----------------------------------------------------------------------------
// cpq_controller - command sequencer
// Steps each command through the datapath: minimum search, gift-wrap
// candidate scan, support scan, edge tests and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module cpq_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output cpq_pkg::ctl_type          ctl,
   input  wire cpq_pkg::status_type  sts
);

   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] S_IDLE       = ST_W'(0);
   localparam logic [ST_W-1:0] S_DISPATCH   = ST_W'(1);
   localparam logic [ST_W-1:0] S_ERROR      = ST_W'(2);
   localparam logic [ST_W-1:0] S_MIN_RD     = ST_W'(3);
   localparam logic [ST_W-1:0] S_MIN_CMP    = ST_W'(4);
   localparam logic [ST_W-1:0] S_BUILD_INIT = ST_W'(5);
   localparam logic [ST_W-1:0] S_STEP_INIT  = ST_W'(6);
   localparam logic [ST_W-1:0] S_CAND_RD    = ST_W'(7);
   localparam logic [ST_W-1:0] S_CAND_DIFF  = ST_W'(8);
   localparam logic [ST_W-1:0] S_CAND_MUL   = ST_W'(9);
   localparam logic [ST_W-1:0] S_CAND_SUM   = ST_W'(10);
   localparam logic [ST_W-1:0] S_CAND_DEC   = ST_W'(11);
   localparam logic [ST_W-1:0] S_WIDE1      = ST_W'(12);
   localparam logic [ST_W-1:0] S_WIDE2      = ST_W'(13);
   localparam logic [ST_W-1:0] S_STEP_END   = ST_W'(14);
   localparam logic [ST_W-1:0] S_OUT_RD     = ST_W'(15);
   localparam logic [ST_W-1:0] S_OUT_EMIT   = ST_W'(16);
   localparam logic [ST_W-1:0] S_SUP_RD     = ST_W'(17);
   localparam logic [ST_W-1:0] S_SUP_MUL    = ST_W'(18);
   localparam logic [ST_W-1:0] S_SUP_SUM    = ST_W'(19);
   localparam logic [ST_W-1:0] S_SUP_CMP    = ST_W'(20);
   localparam logic [ST_W-1:0] S_SUP_EMIT   = ST_W'(21);
   localparam logic [ST_W-1:0] S_CON_LA     = ST_W'(22);
   localparam logic [ST_W-1:0] S_CON_LB     = ST_W'(23);
   localparam logic [ST_W-1:0] S_CON_PB     = ST_W'(24);
   localparam logic [ST_W-1:0] S_CON_DIFF   = ST_W'(25);
   localparam logic [ST_W-1:0] S_CON_MID    = ST_W'(26);
   localparam logic [ST_W-1:0] S_CON_MUL    = ST_W'(27);
   localparam logic [ST_W-1:0] S_CON_SUM    = ST_W'(28);
   localparam logic [ST_W-1:0] S_CON_CHK    = ST_W'(29);
   localparam logic [ST_W-1:0] S_CON_EMIT   = ST_W'(30);

   localparam int CNT_W = cpq_pkg::CNT_W;

   logic [ST_W-1:0]  st_ff, st_in;
   logic [CNT_W-1:0] j_ff, j_in, i_ff, i_in;
   logic [CNT_W-1:0] j_inc, i_inc;

   assign j_inc = j_ff + 1'b1;
   assign i_inc = i_ff + 1'b1;

   always_comb begin
      st_in       = st_ff;
      j_in        = j_ff;
      i_in        = i_ff;
      ctl         = '0;
      ctl.pt_addr = cpq_pkg::IDX_W'(j_ff);
      ctl.lp_addr = cpq_pkg::LIDX_W'(j_ff);
      req_stall   = (st_ff != S_IDLE);

      unique case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.latch = 1'b1;
               st_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            j_in = '0;
            i_in = '0;
            priority if (sts.cmd == cpq_pkg::CMD_CLEAR) begin
               ctl.clear = 1'b1;
               st_in     = S_IDLE;
            end else if (sts.cmd == cpq_pkg::CMD_LOAD) begin
               if (sts.full) begin
                  st_in = S_ERROR;
               end else begin
                  ctl.load = 1'b1;
                  st_in    = S_IDLE;
               end
            end else if (sts.cmd == cpq_pkg::CMD_BUILD) begin
               st_in = (sts.count < CNT_W'(2)) ? S_ERROR : S_MIN_RD;
            end else if (sts.cmd == cpq_pkg::CMD_SUPPORT) begin
               st_in = (sts.count == '0) ? S_ERROR : S_SUP_RD;
            end else if (sts.cmd == cpq_pkg::CMD_CONTAINS) begin
               st_in = (sts.loop_len == '0) ? S_ERROR : S_CON_LA;
            end else begin
               st_in = S_ERROR;
            end
         end
         S_ERROR: begin
            if (sts.out_free) begin
               ctl.emit      = 1'b1;
               ctl.kind      = cpq_pkg::KIND_ERROR;
               ctl.emit_last = 1'b1;
               st_in         = S_IDLE;
            end
         end
         S_MIN_RD: begin
            st_in = S_MIN_CMP;
         end
         S_MIN_CMP: begin
            ctl.min_step = 1'b1;
            ctl.first    = (j_ff == '0);
            j_in         = j_inc;
            st_in        = (j_inc == sts.count) ? S_BUILD_INIT : S_MIN_RD;
         end
         S_BUILD_INIT: begin
            ctl.build_init = 1'b1;
            i_in           = '0;
            st_in          = S_STEP_INIT;
         end
         S_STEP_INIT: begin
            ctl.step_init = 1'b1;
            j_in          = '0;
            st_in         = S_CAND_RD;
         end
         S_CAND_RD: begin
            priority if (j_ff == sts.count) begin
               st_in = S_STEP_END;
            end else if (sts.skip) begin
               j_in = j_inc;
            end else begin
               st_in = S_CAND_DIFF;
            end
         end
         S_CAND_DIFF: begin
            ctl.cand_diff = 1'b1;
            st_in         = S_CAND_MUL;
         end
         S_CAND_MUL: begin
            ctl.mul = 1'b1;
            st_in   = S_CAND_SUM;
         end
         S_CAND_SUM: begin
            ctl.sum = 1'b1;
            st_in   = S_CAND_DEC;
         end
         S_CAND_DEC: begin
            priority if (sts.dec_take) begin
               ctl.take = 1'b1;
               j_in     = j_inc;
               st_in    = S_CAND_RD;
            end else if (sts.dec_wide) begin
               ctl.wide_start = 1'b1;
               st_in          = S_WIDE1;
            end else begin
               j_in  = j_inc;
               st_in = S_CAND_RD;
            end
         end
         S_WIDE1: begin
            if (!sts.wide_busy) begin
               ctl.wide_start  = 1'b1;
               ctl.wide_phase2 = 1'b1;
               st_in           = S_WIDE2;
            end
         end
         S_WIDE2: begin
            ctl.wide_phase2 = 1'b1;
            if (!sts.wide_busy) begin
               ctl.take = sts.wide_take;
               j_in     = j_inc;
               st_in    = S_CAND_RD;
            end
         end
         S_STEP_END: begin
            ctl.advance = 1'b1;
            i_in        = i_inc;
            j_in        = '0;
            st_in       = (i_inc == sts.count) ? S_OUT_RD : S_STEP_INIT;
         end
         S_OUT_RD: begin
            st_in = S_OUT_EMIT;
         end
         S_OUT_EMIT: begin
            if (sts.out_free) begin
               ctl.emit      = 1'b1;
               ctl.kind      = cpq_pkg::KIND_ORDER;
               ctl.emit_last = (j_inc == sts.loop_len);
               j_in          = j_inc;
               st_in         = (j_inc == sts.loop_len) ? S_IDLE : S_OUT_RD;
            end
         end
         S_SUP_RD: begin
            st_in = S_SUP_MUL;
         end
         S_SUP_MUL: begin
            ctl.mul = 1'b1;
            st_in   = S_SUP_SUM;
         end
         S_SUP_SUM: begin
            ctl.sum = 1'b1;
            st_in   = S_SUP_CMP;
         end
         S_SUP_CMP: begin
            ctl.sup_step = 1'b1;
            ctl.first    = (j_ff == '0);
            j_in         = j_inc;
            st_in        = (j_inc == sts.count) ? S_SUP_EMIT : S_SUP_RD;
         end
         S_SUP_EMIT: begin
            if (sts.out_free) begin
               ctl.emit      = 1'b1;
               ctl.kind      = cpq_pkg::KIND_SUPPORT;
               ctl.emit_last = 1'b1;
               st_in         = S_IDLE;
            end
         end
         S_CON_LA: begin
            ctl.lp_addr = cpq_pkg::LIDX_W'(i_ff);
            st_in       = (i_inc >= sts.loop_len) ? S_CON_EMIT : S_CON_LB;
         end
         S_CON_LB: begin
            ctl.lp_addr      = cpq_pkg::LIDX_W'(i_inc);
            ctl.pt_from_loop = 1'b1;
            st_in            = S_CON_PB;
         end
         S_CON_PB: begin
            ctl.lp_addr      = cpq_pkg::LIDX_W'(i_inc);
            ctl.pt_from_loop = 1'b1;
            ctl.con_a        = 1'b1;
            st_in            = S_CON_DIFF;
         end
         S_CON_DIFF: begin
            ctl.con_diff = 1'b1;
            st_in        = S_CON_MID;
         end
         S_CON_MID: begin
            ctl.con_mid = 1'b1;
            st_in       = S_CON_MUL;
         end
         S_CON_MUL: begin
            ctl.mul = 1'b1;
            st_in   = S_CON_SUM;
         end
         S_CON_SUM: begin
            ctl.sum = 1'b1;
            st_in   = S_CON_CHK;
         end
         S_CON_CHK: begin
            ctl.con_check = 1'b1;
            i_in          = i_inc;
            st_in         = sts.cross_neg ? S_CON_EMIT : S_CON_LA;
         end
         S_CON_EMIT: begin
            if (sts.out_free) begin
               ctl.emit      = 1'b1;
               ctl.kind      = cpq_pkg::KIND_CONTAINS;
               ctl.emit_last = 1'b1;
               st_in         = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         st_ff <= st_in;
      end
      j_ff <= j_in;
      i_ff <= i_in;
   end

endmodule

`default_nettype wire

// File: rtl/convex_polygon_order_and_query_core.sv
// ----------------------------------------------------------------------------
// convex_polygon_order_and_query_core - polygon store, gift-wrap and queries
// Stores up to MAX_VERTICES Q8.8 points, builds the gift-wrap index loop,
// answers support and point containment queries.
//
//   channel   dir   handshake             payload
//   req_      in    req_valid/req_stall   command, coord_x, coord_y
//   rsp_      out   rsp_valid/rsp_stall   result_kind, vertex_index, vertex_x,
//                                         vertex_y, inside_res, last
//
// One word at a time. Support scans every point, contains tests the loop
// edges in turn. Build first searches for the start point, then per step
// scans the candidates, ranking two cosines of equal sign on the two 34-step
// serial multipliers.
// Synchronous reset empties the store. Results wait in an output register;
// rsp_stall holds them and the sequencer while a result cannot be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_polygon_order_and_query_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [cpq_pkg::CMD_W-1:0]           req_command,
   input  wire logic signed [cpq_pkg::COORD_W-1:0]  req_coord_x,
   input  wire logic signed [cpq_pkg::COORD_W-1:0]  req_coord_y,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [cpq_pkg::KIND_W-1:0]               rsp_result_kind,
   output logic [cpq_pkg::VIDX_W-1:0]               rsp_vertex_index,
   output logic signed [cpq_pkg::COORD_W-1:0]       rsp_vertex_x,
   output logic signed [cpq_pkg::COORD_W-1:0]       rsp_vertex_y,
   output logic                                     rsp_inside_res,
   output logic                                     rsp_last
);

   cpq_pkg::ctl_type    ctl;
   cpq_pkg::status_type sts;

   cpq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .ctl       (ctl),
      .sts       (sts)
   );

   cpq_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .ctl              (ctl),
      .sts              (sts),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_vertex_x     (rsp_vertex_x),
      .rsp_vertex_y     (rsp_vertex_y),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire
